// ----- design/lucb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lucb_pkg
// Shared constants and round helpers for the 128-bit block cipher
// ----------------------------------------------------------------------------
package lucb_pkg;

  typedef logic [63:0] half_t;
  typedef logic [7:0]  byte_t;
  typedef logic [127:0] key_t;

  localparam logic [0:0] CFG_KEY_FIRST  = 1'b0;
  localparam logic [0:0] CFG_KEY_SECOND = 1'b1;

  localparam byte_t SBOX [256] = '{
    8'h57, 8'h15, 8'h75, 8'h36, 8'h17, 8'h37, 8'h14, 8'h54,
    8'h74, 8'h76, 8'h16, 8'h35, 8'h55, 8'h77, 8'h34, 8'h56,
    8'hdf, 8'h9d, 8'hfd, 8'hbe, 8'h9f, 8'hbf, 8'h9c, 8'hdc,
    8'hfc, 8'hfe, 8'h9e, 8'hbd, 8'hdd, 8'hff, 8'hbc, 8'hde,
    8'hcf, 8'h8d, 8'hed, 8'hae, 8'h8f, 8'haf, 8'h8c, 8'hcc,
    8'hec, 8'hee, 8'h8e, 8'had, 8'hcd, 8'hef, 8'hac, 8'hce,
    8'hd3, 8'h91, 8'hf1, 8'hb2, 8'h93, 8'hb3, 8'h90, 8'hd0,
    8'hf0, 8'hf2, 8'h92, 8'hb1, 8'hd1, 8'hf3, 8'hb0, 8'hd2,
    8'hd7, 8'h95, 8'hf5, 8'hb6, 8'h97, 8'hb7, 8'h94, 8'hd4,
    8'hf4, 8'hf6, 8'h96, 8'hb5, 8'hd5, 8'hf7, 8'hb4, 8'hd6,
    8'h5f, 8'h1d, 8'h7d, 8'h3e, 8'h1f, 8'h3f, 8'h1c, 8'h5c,
    8'h7c, 8'h7e, 8'h1e, 8'h3d, 8'h5d, 8'h7f, 8'h3c, 8'h5e,
    8'hdb, 8'h99, 8'hf9, 8'hba, 8'h9b, 8'hbb, 8'h98, 8'hd8,
    8'hf8, 8'hfa, 8'h9a, 8'hb9, 8'hd9, 8'hfb, 8'hb8, 8'hda,
    8'h43, 8'h01, 8'h61, 8'h22, 8'h03, 8'h23, 8'h00, 8'h40,
    8'h60, 8'h62, 8'h02, 8'h21, 8'h41, 8'h63, 8'h20, 8'h42,
    8'hc3, 8'h81, 8'he1, 8'ha2, 8'h83, 8'ha3, 8'h80, 8'hc0,
    8'he0, 8'he2, 8'h82, 8'ha1, 8'hc1, 8'he3, 8'ha0, 8'hc2,
    8'hc7, 8'h85, 8'he5, 8'ha6, 8'h87, 8'ha7, 8'h84, 8'hc4,
    8'he4, 8'he6, 8'h86, 8'ha5, 8'hc5, 8'he7, 8'ha4, 8'hc6,
    8'hcb, 8'h89, 8'he9, 8'haa, 8'h8b, 8'hab, 8'h88, 8'hc8,
    8'he8, 8'hea, 8'h8a, 8'ha9, 8'hc9, 8'heb, 8'ha8, 8'hca,
    8'h4b, 8'h09, 8'h69, 8'h2a, 8'h0b, 8'h2b, 8'h08, 8'h48,
    8'h68, 8'h6a, 8'h0a, 8'h29, 8'h49, 8'h6b, 8'h28, 8'h4a,
    8'h5b, 8'h19, 8'h79, 8'h3a, 8'h1b, 8'h3b, 8'h18, 8'h58,
    8'h78, 8'h7a, 8'h1a, 8'h39, 8'h59, 8'h7b, 8'h38, 8'h5a,
    8'h47, 8'h05, 8'h65, 8'h26, 8'h07, 8'h27, 8'h04, 8'h44,
    8'h64, 8'h66, 8'h06, 8'h25, 8'h45, 8'h67, 8'h24, 8'h46,
    8'h4f, 8'h0d, 8'h6d, 8'h2e, 8'h0f, 8'h2f, 8'h0c, 8'h4c,
    8'h6c, 8'h6e, 8'h0e, 8'h2d, 8'h4d, 8'h6f, 8'h2c, 8'h4e,
    8'h53, 8'h11, 8'h71, 8'h32, 8'h13, 8'h33, 8'h10, 8'h50,
    8'h70, 8'h72, 8'h12, 8'h31, 8'h51, 8'h73, 8'h30, 8'h52
  };

  localparam byte_t DIFF_ROW [8] = '{
    8'h04, 8'h10, 8'h20, 8'h02, 8'h01, 8'h08, 8'h40, 8'h80
  };

  localparam logic [2:0] BIT_PERM [8] = '{
    3'd3, 3'd5, 3'd0, 3'd4, 3'd2, 3'd1, 3'd7, 3'd6
  };

  // key byte n, byte 0 at the top of the 128-bit key
  function automatic byte_t key_byte(key_t k, logic [3:0] n);
    return k[8'd127 - {n, 3'd0} -: 8];
  endfunction

  // bit permutation of one key byte
  function automatic byte_t permute_byte(byte_t b);
    byte_t r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[3'd7 - BIT_PERM[i]] = b[7 - i];
    end
    return r;
  endfunction

endpackage : lucb_pkg
`default_nettype wire

// ----- design/lucb_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lucb_round
// One cipher round: control byte, s-box pick, key xor and diffusion
// ----------------------------------------------------------------------------
module lucb_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  lucb_pkg::key_t  key,
  input  lucb_pkg::half_t lo_in,
  input  lucb_pkg::half_t hi_in,
  output lucb_pkg::half_t lo_out
);
  import lucb_pkg::*;

  // index at round start is 8 + 8*round (mod 16); control byte uses idx itself
  localparam logic [3:0] CtlIdx  = 4'(8 + 8 * RoundIdx);
  localparam logic [3:0] KeyBase = 4'(9 + 8 * RoundIdx);

  byte_t ctl;
  byte_t hb  [8];
  byte_t val [8];
  byte_t lb  [8];

  // control byte from key byte and all bytes of the fixed half
  always_comb begin
    ctl = key_byte(key, CtlIdx);
    for (int j = 0; j < 8; j++) begin
      hb[j] = hi_in[63 - 8 * j -: 8];
      ctl   = ctl ^ hb[j];
    end
  end

  // s-box lookups and diffusion into the modified half
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      val[j] = ctl[7 - j] ? SBOX[{hb[j][3:0], hb[j][7:4]}] : SBOX[hb[j]];
      val[j] = val[j] ^ permute_byte(key_byte(key, 4'(KeyBase + 4'(j))));
    end
    for (int k = 0; k < 8; k++) begin
      lb[k] = lo_in[63 - 8 * k -: 8];
      for (int j = 0; j < 8; j++) begin
        lb[k] = lb[k] ^ (val[j] & DIFF_ROW[(k - j) & 7]);
      end
      lo_out[63 - 8 * k -: 8] = lb[k];
    end
  end

endmodule : lucb_round
`default_nettype wire

// ----- design/lucifer_block_encrypt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lucifer_block_encrypt
// 128-bit block encryption under a 128-bit key, fully unrolled rounds
// ----------------------------------------------------------------------------
// Usage:
//   The key is loaded through cfg_we / cfg_index / cfg_wdata: index 0 holds
//   key bytes 0..7, index 1 key bytes 8..15; cfg_index has no other values.
//   Write the key only while no block is in flight.
//   A block is taken on a clock edge with start high and busy low; busy is
//   always low, so one transaction can be taken every cycle.
//   The block is captured in an input register, all ROUNDS rounds run as one
//   unrolled chain of round logic, and the ciphertext is registered.
//   A block passes the input then the result register; throughput is one block
//   per cycle, set by the single unrolled round chain between the registers.
//   out_valid pulses for one cycle with the result; the receiver cannot stall.
//   Reset clears the key to zero and drops any block in flight.
// ----------------------------------------------------------------------------
module lucifer_block_encrypt #(
  parameter int unsigned ROUNDS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  lucb_pkg::half_t       in_block_first_half,
  input  lucb_pkg::half_t       in_block_second_half,
  output logic                  out_valid,
  output lucb_pkg::half_t       out_cipher_first_half,
  output lucb_pkg::half_t       out_cipher_second_half,
  input  wire                   cfg_we,
  input  wire  [0:0]            cfg_index,
  input  lucb_pkg::half_t       cfg_wdata
);
  import lucb_pkg::*;

  half_t key_hi_r, key_lo_r;
  half_t blk_a_r, blk_b_r;
  logic  in_vld_r;
  half_t ct_a_r, ct_b_r;
  logic  out_vld_r;
  key_t  key;
  half_t st [ROUNDS + 1][2];

  assign busy = 1'b0;
  assign key  = {key_hi_r, key_lo_r};

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_FIRST:  key_hi_r <= cfg_wdata;
        CFG_KEY_SECOND: key_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= start;
  end
  always_ff @(posedge clk) begin
    if (start) begin
      blk_a_r <= in_block_first_half;
      blk_b_r <= in_block_second_half;
    end
  end

  // unrolled round chain, halves swap roles each round
  assign st[0][0] = blk_a_r;
  assign st[0][1] = blk_b_r;
  for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
    half_t nl;
    lucb_round #(.RoundIdx(r)) u_round (
      .key    (key),
      .lo_in  (st[r][r % 2]),
      .hi_in  (st[r][(r + 1) % 2]),
      .lo_out (nl)
    );
    assign st[r + 1][r % 2]       = nl;
    assign st[r + 1][(r + 1) % 2] = st[r][(r + 1) % 2];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= in_vld_r;
  end
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      ct_a_r <= st[ROUNDS][1];
      ct_b_r <= st[ROUNDS][0];
    end
  end

  assign out_valid              = out_vld_r;
  assign out_cipher_first_half  = ct_a_r;
  assign out_cipher_second_half = ct_b_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid) else $error("result missing two cycles after start");
  a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 2)) else $error("result without a transaction");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> $stable(ct_a_r) && $stable(ct_b_r)) else $error("result changed while idle");

endmodule : lucifer_block_encrypt
`default_nettype wire
